[hdl/fca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_pkg
// shared codes, marks, state type and control/status words for the
// allocation table block
// ----------------------------------------------------------------------------
package fca_pkg;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_ALLOC = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_ZERO_LEN = 2'd2;

    // entry marks
    localparam logic [31:0] END_MARK = 32'hFFFF_FFFF;
    localparam logic [31:0] RES_MARK = 32'h0000_0001;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_CHECK,
        ST_SCAN,
        ST_TAIL,
        ST_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic look_apply;
        logic check_en;
        logic scan_run;
        logic tail_wr;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       clear_done;
        logic [1:0] cmd;
        logic       zero_req;
        logic       no_space;
        logic       found_last;
        logic       out_free;
    } dp_stat_t;

endpackage

[hdl/fca_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_ctrl
// sequencer: clearing pass, command dispatch, allocation scan and result
// hand-off
// ----------------------------------------------------------------------------
module fca_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fca_pkg::dp_stat_t stat,
    output fca_pkg::ctrl_cmd_t cmd
);

    fca_pkg::state_t state_reg;
    fca_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fca_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            fca_pkg::ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = fca_pkg::ST_IDLE;
                end
            end
            fca_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = fca_pkg::ST_DISPATCH;
                end
            end
            fca_pkg::ST_DISPATCH:
            begin
                case (stat.cmd)
                    fca_pkg::CMD_WRITE,
                    fca_pkg::CMD_READ:
                    begin
                        cmd.look_apply = 1'b1;
                        state_next     = fca_pkg::ST_RESP;
                    end
                    fca_pkg::CMD_ALLOC:
                    begin
                        state_next = fca_pkg::ST_CHECK;
                    end
                    default:
                    begin
                        state_next = fca_pkg::ST_RESP;
                    end
                endcase
            end
            fca_pkg::ST_CHECK:
            begin
                cmd.check_en = 1'b1;
                if (stat.zero_req || stat.no_space)
                begin
                    state_next = fca_pkg::ST_RESP;
                end
                else
                begin
                    state_next = fca_pkg::ST_SCAN;
                end
            end
            fca_pkg::ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.found_last)
                begin
                    state_next = fca_pkg::ST_TAIL;
                end
            end
            fca_pkg::ST_TAIL:
            begin
                cmd.tail_wr = 1'b1;
                state_next  = fca_pkg::ST_RESP;
            end
            fca_pkg::ST_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = fca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fca_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/fca_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_datapath
// table memory, class counters, scan pointers and output register
// ----------------------------------------------------------------------------
module fca_datapath
#(
    parameter int FAT_ENTRIES = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         command,
    input  logic [9:0]         entry_index,
    input  logic [31:0]        entry_value,
    input  logic [10:0]        blocks_wanted,
    input  logic [10:0]        extra_dirs,
    input  fca_pkg::ctrl_cmd_t cmd,
    output fca_pkg::dp_stat_t  stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [31:0]        read_value,
    output logic [9:0]         chain_head,
    output logic [10:0]        free_total,
    output logic [10:0]        reserved_total,
    output logic [10:0]        allocated_total
);

    localparam int IW = $clog2(FAT_ENTRIES);
    localparam int CW = $clog2(FAT_ENTRIES + 1);
    localparam int SW = (CW > 12) ? CW : 12;

    // table memory
    logic [31:0]   fat_mem [FAT_ENTRIES];
    logic [31:0]   rdata_reg;
    logic          re;
    logic [IW-1:0] raddr;
    logic          we;
    logic [IW-1:0] waddr;
    logic [31:0]   wdata;

    // latched item
    logic [1:0]    cmd_reg;
    logic [IW-1:0] idx_reg;
    logic [31:0]   val_reg;
    logic [10:0]   need_reg;
    logic [10:0]   dirs_reg;
    logic          in_range_reg;

    // scan state
    logic [IW:0]   scan_ptr_reg;
    logic [IW-1:0] tag_reg;
    logic          tag_valid_reg;
    logic [IW-1:0] prev_reg;
    logic          have_prev_reg;
    logic [10:0]   got_reg;
    logic [IW-1:0] clear_ptr_reg;

    // result fields
    logic [1:0]    status_reg;
    logic [31:0]   rd_value_reg;
    logic [IW-1:0] start_reg;
    logic          out_valid_reg;
    logic [1:0]    status_out_reg;
    logic [31:0]   read_value_out_reg;
    logic [9:0]    start_out_reg;
    logic [10:0]   free_out_reg;
    logic [10:0]   res_out_reg;
    logic [10:0]   alloc_out_reg;

    // class counters
    logic [CW-1:0] free_reg;
    logic [CW-1:0] free_next;
    logic [CW-1:0] res_reg;
    logic [CW-1:0] res_next;
    logic [CW-1:0] alloc_reg;
    logic [CW-1:0] alloc_next;

    logic [31:0]   idx_wide;
    logic          idx_in_range;
    logic          scan_rd_en;
    logic          found;
    logic          link_is_one;
    logic          write_apply;
    logic [SW-1:0] req_sum;
    logic [31:0]   start_wide;
    logic [31:0]   free_wide;
    logic [31:0]   res_wide;
    logic [31:0]   alloc_wide;
    logic          old_free;
    logic          old_res;
    logic          new_free;
    logic          new_res;

    assign idx_wide     = 32'(entry_index);
    assign idx_in_range = idx_wide < 32'(FAT_ENTRIES);
    assign scan_rd_en   = scan_ptr_reg < (IW + 1)'(FAT_ENTRIES);
    assign found        = tag_valid_reg && (rdata_reg == 32'd0);
    assign link_is_one  = have_prev_reg && (tag_reg == IW'(1));
    assign write_apply  = cmd.look_apply && (cmd_reg == fca_pkg::CMD_WRITE) && in_range_reg;
    assign req_sum      = SW'(need_reg) + SW'(dirs_reg);

    assign old_free = (rdata_reg == 32'd0);
    assign old_res  = (rdata_reg == fca_pkg::RES_MARK);
    assign new_free = (val_reg == 32'd0);
    assign new_res  = (val_reg == fca_pkg::RES_MARK);

    assign stat.clear_done = (clear_ptr_reg == IW'(FAT_ENTRIES - 1));
    assign stat.cmd        = cmd_reg;
    assign stat.zero_req   = (need_reg == 11'd0);
    assign stat.no_space   = SW'(free_reg) < req_sum;
    assign stat.found_last = found && ((got_reg + 11'd1) == need_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // memory port select
    always_comb
    begin
        re    = 1'b0;
        raddr = scan_ptr_reg[IW-1:0];
        if (cmd.accept)
        begin
            re    = 1'b1;
            raddr = idx_wide[IW-1:0];
        end
        else if (cmd.scan_run)
        begin
            re = scan_rd_en;
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = prev_reg;
        wdata = fca_pkg::END_MARK;
        if (cmd.clear_en)
        begin
            we    = 1'b1;
            waddr = clear_ptr_reg;
            wdata = 32'd0;
        end
        else if (write_apply)
        begin
            we    = 1'b1;
            waddr = idx_reg;
            wdata = val_reg;
        end
        else if (cmd.scan_run && found && have_prev_reg)
        begin
            we    = 1'b1;
            wdata = 32'(tag_reg);
        end
        else if (cmd.tail_wr)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            fat_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= fat_mem[raddr];
        end
    end

    // counters follow the class of each entry change
    always_comb
    begin
        free_next  = free_reg;
        res_next   = res_reg;
        alloc_next = alloc_reg;
        if (write_apply)
        begin
            free_next  = free_reg + CW'(new_free) - CW'(old_free);
            res_next   = res_reg + CW'(new_res) - CW'(old_res);
            alloc_next = alloc_reg + CW'(!new_free && !new_res)
                         - CW'(!old_free && !old_res);
        end
        else if (cmd.scan_run && found)
        begin
            free_next = free_reg - CW'(1);
            if (link_is_one)
            begin
                res_next = res_reg + CW'(1);
            end
            else
            begin
                alloc_next = alloc_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg      <= CW'(FAT_ENTRIES);
            res_reg       <= '0;
            alloc_reg     <= '0;
            clear_ptr_reg <= '0;
            tag_valid_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            free_reg  <= free_next;
            res_reg   <= res_next;
            alloc_reg <= alloc_next;
            if (cmd.clear_en)
            begin
                clear_ptr_reg <= clear_ptr_reg + IW'(1);
            end
            if (cmd.check_en)
            begin
                tag_valid_reg <= 1'b0;
                have_prev_reg <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                tag_valid_reg <= scan_rd_en;
                if (found)
                begin
                    have_prev_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign start_wide = 32'(start_reg);
    assign free_wide  = 32'(free_reg);
    assign res_wide   = 32'(res_reg);
    assign alloc_wide = 32'(alloc_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg      <= command;
            idx_reg      <= idx_wide[IW-1:0];
            val_reg      <= entry_value;
            need_reg     <= blocks_wanted;
            dirs_reg     <= extra_dirs;
            in_range_reg <= idx_in_range;
            status_reg   <= fca_pkg::STATUS_OK;
            rd_value_reg <= 32'd0;
            start_reg    <= '0;
        end
        if (cmd.look_apply && (cmd_reg == fca_pkg::CMD_READ) && in_range_reg)
        begin
            rd_value_reg <= rdata_reg;
        end
        if (cmd.check_en)
        begin
            scan_ptr_reg <= '0;
            got_reg      <= 11'd0;
            if (need_reg == 11'd0)
            begin
                status_reg <= fca_pkg::STATUS_ZERO_LEN;
            end
            else if (stat.no_space)
            begin
                status_reg <= fca_pkg::STATUS_NO_SPACE;
            end
        end
        if (cmd.scan_run)
        begin
            if (scan_rd_en)
            begin
                scan_ptr_reg <= scan_ptr_reg + (IW + 1)'(1);
                tag_reg      <= scan_ptr_reg[IW-1:0];
            end
            if (found)
            begin
                if (!have_prev_reg)
                begin
                    start_reg <= tag_reg;
                end
                prev_reg <= tag_reg;
                got_reg  <= got_reg + 11'd1;
            end
        end
        if (cmd.out_load)
        begin
            status_out_reg     <= status_reg;
            read_value_out_reg <= rd_value_reg;
            start_out_reg      <= start_wide[9:0];
            free_out_reg       <= free_wide[10:0];
            res_out_reg        <= res_wide[10:0];
            alloc_out_reg      <= alloc_wide[10:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_out_reg;
    assign read_value      = read_value_out_reg;
    assign chain_head      = start_out_reg;
    assign free_total      = free_out_reg;
    assign reserved_total  = res_out_reg;
    assign allocated_total = alloc_out_reg;

`ifndef SYNTHESIS
    // the three classes always cover the whole table
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ((CW + 2)'(free_reg) + (CW + 2)'(res_reg) + (CW + 2)'(alloc_reg))
        == (CW + 2)'(FAT_ENTRIES))
        else $error("class counts do not sum to table size");

    // a link always points forward, behind the read pointer
    a_link_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_run && found && have_prev_reg) |-> (prev_reg < tag_reg))
        else $error("chain link does not point forward");

    // the end marker goes onto a claimed entry
    a_tail_claimed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tail_wr |-> have_prev_reg)
        else $error("chain tail written with no claimed entry");

    // a waiting result is never overwritten
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a word not yet taken");
`endif

endmodule

[hdl/fat_chain_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_allocator
// file allocation table with first-fit chain allocation and class counters
// ----------------------------------------------------------------------------
// The block holds a table of FAT_ENTRIES 32-bit entries (0 free, 1 reserved,
// anything else allocated) in a single memory, plus running counts of free,
// reserved and allocated entries. After reset a clearing pass writes zero to
// every entry, one a cycle, and no word is accepted until it is done. One
// word is worked on at a time and its result sits in an output register, so
// the next word is taken while the result waits. A write, a read or an unused
// command goes from dispatch straight to the result step. An allocation is
// first checked, then scans the table from entry 0 through the memory's read
// port, one entry a cycle, and stops at the last block it claims; a refused
// or zero-length allocation goes from the check straight to the result step.
// A result still waiting in the output register holds the block in its last
// step until it is taken. Each claimed entry costs one memory write, its link
// to the next being written when the next free entry is found and the end
// marker into the last one after the scan.
// ----------------------------------------------------------------------------
module fat_chain_allocator
#(
    parameter int FAT_ENTRIES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    // command word
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [9:0]  entry_index,
    input  logic [31:0] entry_value,
    input  logic [10:0] blocks_wanted,
    input  logic [10:0] extra_dirs,
    // result word
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] read_value,
    output logic [9:0]  chain_head,
    output logic [10:0] free_total,
    output logic [10:0] reserved_total,
    output logic [10:0] allocated_total
);

    // command and status words between the sequencer and the datapath
    fca_pkg::ctrl_cmd_t ctrl_cmd;
    fca_pkg::dp_stat_t  dp_stat;

    // sequencer: clearing pass, dispatch, scan, result hand-off
    fca_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    // table memory, counters, scan pointers and output register
    fca_datapath #(
        .FAT_ENTRIES (FAT_ENTRIES)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .command         (command),
        .entry_index     (entry_index),
        .entry_value     (entry_value),
        .blocks_wanted   (blocks_wanted),
        .extra_dirs      (extra_dirs),
        .cmd             (ctrl_cmd),
        .stat            (dp_stat),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .read_value      (read_value),
        .chain_head      (chain_head),
        .free_total      (free_total),
        .reserved_total  (reserved_total),
        .allocated_total (allocated_total)
    );

endmodule
